/* sv/mct_pkg.sv */
// package: sizes, payload structs, codes and helpers of the matrix clock tracker
package mct_pkg;

    localparam int NUM_PROCS  = 4;
    localparam int COUNT_BITS = 32;
    localparam int CELLS      = NUM_PROCS * NUM_PROCS;
    localparam int IDX_W      = $clog2(NUM_PROCS);
    localparam int CELL_W     = $clog2(CELLS);
    localparam int VALUE_W    = 32;
    localparam int WIDE_W     = (COUNT_BITS > VALUE_W) ? COUNT_BITS : VALUE_W;

    // request op codes
    localparam logic [1:0] OP_LOCAL = 2'd0;
    localparam logic [1:0] OP_SEND  = 2'd1;
    localparam logic [1:0] OP_RECV  = 2'd2;

    typedef logic [COUNT_BITS-1:0] t_count;
    typedef logic [IDX_W-1:0]      t_idx;
    typedef logic [CELL_W-1:0]     t_cell;

    typedef struct packed {
        logic [1:0]         op;
        logic [1:0]         dest;
        logic [1:0]         in_row;
        logic [1:0]         in_col;
        logic [VALUE_W-1:0] in_value;
        logic               msg_start;
    } t_in;

    typedef struct packed {
        logic [1:0]         out_row;
        logic [1:0]         out_col;
        logic [VALUE_W-1:0] out_value;
        logic               last;
    } t_out;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_MOD,
        S_STREAM_RD,
        S_STREAM_OUT
    } t_state;

    // kind of read-modify-write in flight
    typedef enum logic [1:0] {
        U_DIAG,
        U_DEST,
        U_MERGE,
        U_ZERO
    } t_uop;

    // saturating increment
    function automatic t_count sat_inc(input t_count c);
        return (&c) ? c : c + 1'b1;
    endfunction

    // clip an incoming value to the counter range
    function automatic t_count clip_in(input logic [VALUE_W-1:0] v);
        logic [WIDE_W-1:0] w;
        logic [WIDE_W-1:0] cmax;
        w    = WIDE_W'(v);
        cmax = WIDE_W'({COUNT_BITS{1'b1}});
        return (w > cmax) ? COUNT_BITS'(cmax) : COUNT_BITS'(w);
    endfunction

    // counter to reported value, low bits
    function automatic logic [VALUE_W-1:0] to_out(input t_count c);
        logic [WIDE_W-1:0] w;
        w = WIDE_W'(c);
        return w[VALUE_W-1:0];
    endfunction

    // row-major cell index
    function automatic t_cell cell_of(input t_idx row, input t_idx col);
        return CELL_W'(int'(row) * NUM_PROCS + int'(col));
    endfunction

    // index field within the matrix
    function automatic logic in_range(input logic [1:0] v);
        return int'(v) < NUM_PROCS;
    endfunction

endpackage

/* sv/mct_ram.sv */
// generic single-port-write, single-port-read ram with registered read data
module mct_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/matrix_clock_tracker.sv */
// matrix clock tracker top level: request sequencer around the counter ram
// one request at a time; each counter update is a read-modify-write on the ram port (read state, then modify state)
// local event or receive: one registered result entry; a receive with msg_start first bumps the diagonal
// send: two updates, then a read state and an output state per matrix element, in row-major order
// output stalls hold the sequencer; the next request is taken once back in idle
// synchronous reset clears per-entry valid bits (matrix reads zero) and sets the own index to 1
module matrix_clock_tracker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  mct_pkg::t_in  i_in,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output mct_pkg::t_out o_out,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_data
);
    import mct_pkg::*;

    t_state           r_state, n_state;
    t_uop             r_uop, n_uop;
    t_cell            r_addr, n_addr;
    t_cell            r_k, n_k;
    t_in              r_req, n_req;
    t_out             r_out, n_out;
    logic             r_out_valid, n_out_valid;
    logic [1:0]       r_own_id;
    logic [CELLS-1:0] r_valid;
    logic             r_rd_valid;

    logic   ram_we, ram_re;
    t_cell  ram_raddr;
    t_count ram_rdata, cur, mod_value;
    t_idx   me;
    t_cell  diag;
    logic   out_free, emit;

    // own index, clamped
    assign me   = in_range(r_own_id) ? IDX_W'(r_own_id) : IDX_W'(NUM_PROCS - 1);
    assign diag = cell_of(me, me);

    assign out_free = !r_out_valid || i_out_ready;
    assign cur      = r_rd_valid ? ram_rdata : '0;

    // modify step
    always_comb begin
        case (r_uop)
            U_MERGE: mod_value = (clip_in(r_req.in_value) > cur) ? clip_in(r_req.in_value) : cur;
            default: mod_value = sat_inc(cur);
        endcase
    end

    assign emit = (r_uop == U_DIAG && r_req.op == OP_LOCAL) || r_uop == U_MERGE
                  || r_uop == U_ZERO;

    // counter storage
    mct_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (CELLS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_addr),
        .i_wdata (mod_value),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // next state and outputs
    always_comb begin
        n_state     = r_state;
        n_uop       = r_uop;
        n_addr      = r_addr;
        n_k         = r_k;
        n_req       = r_req;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        ram_raddr   = r_addr;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_req = i_in;
                    case (i_in.op)
                        OP_LOCAL, OP_SEND: begin
                            n_uop   = U_DIAG;
                            n_addr  = diag;
                            n_state = S_RD;
                        end
                        OP_RECV: begin
                            if (i_in.msg_start) begin
                                n_uop   = U_DIAG;
                                n_addr  = diag;
                                n_state = S_RD;
                            end else if (in_range(i_in.in_row) && in_range(i_in.in_col)) begin
                                n_uop   = U_MERGE;
                                n_addr  = cell_of(IDX_W'(i_in.in_row), IDX_W'(i_in.in_col));
                                n_state = S_RD;
                            end else begin
                                n_uop   = U_ZERO;
                                n_state = S_MOD;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_RD: begin
                ram_re  = 1'b1;
                n_state = S_MOD;
            end
            S_MOD: begin
                if (!emit || out_free) begin
                    ram_we = (r_uop != U_ZERO);
                    if (emit) begin
                        n_out_valid = 1'b1;
                        n_out.last  = 1'b1;
                        if (r_uop == U_DIAG) begin
                            n_out.out_row = 2'(me);
                            n_out.out_col = 2'(me);
                        end else begin
                            n_out.out_row = r_req.in_row;
                            n_out.out_col = r_req.in_col;
                        end
                        n_out.out_value = (r_uop == U_ZERO) ? '0 : to_out(mod_value);
                    end
                    case (r_uop)
                        U_DIAG: begin
                            case (r_req.op)
                                OP_LOCAL: n_state = S_IDLE;
                                OP_SEND: begin
                                    if (in_range(r_req.dest)) begin
                                        n_uop   = U_DEST;
                                        n_addr  = cell_of(me, IDX_W'(r_req.dest));
                                        n_state = S_RD;
                                    end else begin
                                        n_k     = '0;
                                        n_state = S_STREAM_RD;
                                    end
                                end
                                default: begin
                                    if (in_range(r_req.in_row) && in_range(r_req.in_col)) begin
                                        n_uop   = U_MERGE;
                                        n_addr  = cell_of(IDX_W'(r_req.in_row),
                                                          IDX_W'(r_req.in_col));
                                        n_state = S_RD;
                                    end else begin
                                        n_uop   = U_ZERO;
                                        n_state = S_MOD;
                                    end
                                end
                            endcase
                        end
                        U_DEST: begin
                            n_k     = '0;
                            n_state = S_STREAM_RD;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_STREAM_RD: begin
                ram_re    = 1'b1;
                ram_raddr = r_k;
                n_state   = S_STREAM_OUT;
            end
            S_STREAM_OUT: begin
                if (out_free) begin
                    n_out_valid     = 1'b1;
                    n_out.out_row   = 2'(r_k / NUM_PROCS);
                    n_out.out_col   = 2'(r_k % NUM_PROCS);
                    n_out.out_value = to_out(cur);
                    n_out.last      = (r_k == CELL_W'(CELLS - 1));
                    if (r_k == CELL_W'(CELLS - 1)) begin
                        n_state = S_IDLE;
                    end else begin
                        n_k     = r_k + 1'b1;
                        n_state = S_STREAM_RD;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // payload and sequencing registers
    always_ff @(posedge i_clk) begin
        r_uop  <= n_uop;
        r_addr <= n_addr;
        r_k    <= n_k;
        r_req  <= n_req;
        r_out  <= n_out;
    end

    // per-entry valid bits, an unwritten entry reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (ram_we) begin
            r_valid[r_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ram_re) begin
            r_rd_valid <= r_valid[ram_raddr];
        end
    end

    // own index register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_id <= 2'd1;
        end else if (i_cfg_we) begin
            r_own_id <= i_cfg_data;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

/* sim/testbench.sv */
// testbench: matrix clock tracker checked against a predicted matrix under random flow control
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import mct_pkg::*;

    // unused op code, the block must ignore it
    localparam logic [1:0] OP_NONE = 2'd3;
    localparam t_count COUNT_MAX   = '1;
    localparam int QUIET_LIMIT     = 2000;
    localparam int CFG_SETTLE      = 40;
    localparam int END_TAIL        = 50;
    localparam int HOLD_CYCLES     = 150;

    // predicted matrix state and queue of matrix entries still to arrive
    class clock_matrix_model;
        t_count     clock_cells[CELLS];
        logic [1:0] self_id;
        t_out       expected_entries[$];
        int         errors;
        int         entries_checked;
        int         n_local;
        int         n_send;
        int         n_recv;
        int         n_ignored;

        function new();
            foreach (clock_cells[i]) clock_cells[i] = '0;
            self_id = 2'd1;
        endfunction

        function void set_process(logic [1:0] id);
            self_id = id;
        endfunction

        function int pending();
            return expected_entries.size();
        endfunction

        // saturating increment of one counter
        function void bump(int c);
            if (clock_cells[c] != COUNT_MAX) clock_cells[c] = clock_cells[c] + 1'b1;
        endfunction

        function void add_entry(logic [1:0] r, logic [1:0] c, t_count v, logic fin);
            t_out e;
            e.out_row   = r;
            e.out_col   = c;
            e.out_value = VALUE_W'(v);
            e.last      = fin;
            expected_entries.push_back(e);
        endfunction

        // update the matrix for one accepted request and queue its entries
        function void note_request(t_in req);
            int     me;
            int     diag;
            int     c;
            t_count merged;
            me   = (int'(self_id) >= NUM_PROCS) ? NUM_PROCS - 1 : int'(self_id);
            diag = me * NUM_PROCS + me;
            case (req.op)
                OP_LOCAL: begin
                    n_local++;
                    bump(diag);
                    add_entry(2'(me), 2'(me), clock_cells[diag], 1'b1);
                end
                OP_SEND: begin
                    n_send++;
                    bump(diag);
                    if (int'(req.dest) < NUM_PROCS) bump(me * NUM_PROCS + int'(req.dest));
                    for (c = 0; c < CELLS; c++)
                        add_entry(2'(c / NUM_PROCS), 2'(c % NUM_PROCS), clock_cells[c],
                                  c == CELLS - 1);
                end
                OP_RECV: begin
                    n_recv++;
                    if (req.msg_start) bump(diag);
                    if (int'(req.in_row) < NUM_PROCS && int'(req.in_col) < NUM_PROCS) begin
                        c = int'(req.in_row) * NUM_PROCS + int'(req.in_col);
                        merged = (64'(req.in_value) > 64'(COUNT_MAX)) ?
                                 COUNT_MAX : t_count'(req.in_value);
                        if (merged > clock_cells[c]) clock_cells[c] = merged;
                        add_entry(req.in_row, req.in_col, clock_cells[c], 1'b1);
                    end else begin
                        add_entry(req.in_row, req.in_col, '0, 1'b1);
                    end
                end
                default: begin
                    n_ignored++;
                end
            endcase
        endfunction

        // compare one delivered entry with the oldest prediction
        function void check_result(t_out got);
            t_out want;
            if (expected_entries.size() == 0) begin
                errors++;
                if (errors <= 20)
                    $display("%0t: unexpected entry row %0d col %0d value %h last %b",
                             $time, got.out_row, got.out_col, got.out_value, got.last);
                return;
            end
            want = expected_entries.pop_front();
            entries_checked++;
            if (got.out_row !== want.out_row || got.out_col !== want.out_col ||
                got.out_value !== want.out_value || got.last !== want.last) begin
                errors++;
                if (errors <= 20)
                    $display("%0t: expected %0d/%0d %h %b, got %0d/%0d %h %b",
                             $time, want.out_row, want.out_col, want.out_value, want.last,
                             got.out_row, got.out_col, got.out_value, got.last);
            end
        endfunction
    endclass

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    logic       o_in_ready;
    t_in        i_in        = '0;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    t_out       o_out;
    logic       i_cfg_we    = 1'b0;
    logic [1:0] i_cfg_data  = 2'd0;

    clock_matrix_model tracker_model;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_req       = 0;
    int quiet_cycles   = 0;

    matrix_clock_tracker dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // receiver: random stalls, or one long hold-off when asked
    initial begin
        int n;
        forever begin
            @(posedge i_clk);
            if (hold_req > 0) begin
                n = hold_req;
                hold_req = 0;
                i_out_ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // handshake monitor and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) tracker_model.note_request(i_in);
            if (o_out_valid && i_out_ready) tracker_model.check_result(o_out);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t: no request or entry moved for %0d cycles, %0d entries outstanding",
                         $time, QUIET_LIMIT, tracker_model.pending());
                $display("** matrix_clock_tracker: FAILED **");
                $finish;
            end
        end
    end

    function automatic t_in make_request(logic [1:0] op, logic [1:0] dest, logic [1:0] row,
                                         logic [1:0] col, logic [31:0] val, logic start);
        t_in r;
        r.op        = op;
        r.dest      = dest;
        r.in_row    = row;
        r.in_col    = col;
        r.in_value  = val;
        r.msg_start = start;
        return r;
    endfunction

    // random request of one kind; values mostly small so merges go both ways
    function automatic t_in rand_request(logic [1:0] op, logic start);
        logic [31:0] val;
        case ($urandom_range(9))
            0:       val = '1;
            1, 2:    val = $urandom;
            default: val = $urandom_range(60);
        endcase
        return make_request(op, 2'($urandom), 2'($urandom), 2'($urandom), val, start);
    endfunction

    // offer one request, possibly after idle cycles; returns at the accepting edge
    task automatic drive_request(input t_in req);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= req;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // stop offering and wait until every predicted entry has arrived
    task automatic settle(input int tail);
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (tracker_model.pending() != 0);
        repeat (tail) @(posedge i_clk);
    endtask

    task automatic write_own_id(input logic [1:0] id);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= id;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        tracker_model.set_process(id);
    endtask

    // directed corners: self send, saturation, smaller and larger merges, unused op
    task automatic run_directed();
        t_in d[$];
        d.push_back(make_request(OP_LOCAL, 2'd0, 2'd0, 2'd0, 32'd0, 1'b0));
        d.push_back(make_request(OP_SEND,  2'd0, 2'd0, 2'd0, 32'd0, 1'b0));
        d.push_back(make_request(OP_SEND,  2'd3, 2'd0, 2'd0, 32'd0, 1'b0));
        d.push_back(make_request(OP_RECV,  2'd0, 2'd0, 2'd0, 32'd5, 1'b1));
        d.push_back(make_request(OP_RECV,  2'd0, 2'd3, 2'd3, 32'd0, 1'b0));
        d.push_back(make_request(OP_RECV,  2'd0, 2'd1, 2'd2, 32'hFFFF_FFFF, 1'b0));
        d.push_back(make_request(OP_RECV,  2'd0, 2'd3, 2'd3, 32'hFFFF_FFFF, 1'b0));
        d.push_back(make_request(OP_LOCAL, 2'd3, 2'd3, 2'd3, 32'hFFFF_FFFF, 1'b1));
        d.push_back(make_request(OP_SEND,  2'd3, 2'd0, 2'd0, 32'd0, 1'b0));
        d.push_back(make_request(OP_RECV,  2'd0, 2'd2, 2'd1, 32'h8000_0000, 1'b1));
        d.push_back(make_request(OP_NONE,  2'd3, 2'd3, 2'd3, 32'hFFFF_FFFF, 1'b1));
        d.push_back(make_request(OP_RECV,  2'd0, 2'd3, 2'd0, 32'd0, 1'b1));
        d.push_back(make_request(OP_SEND,  2'd1, 2'd0, 2'd0, 32'd0, 1'b0));
        d.push_back(make_request(OP_SEND,  2'd2, 2'd2, 2'd1, 32'h5555_AAAA, 1'b1));
        d.push_back(make_request(OP_RECV,  2'd3, 2'd0, 2'd3, 32'h7FFF_FFFF, 1'b0));
        d.push_back(make_request(OP_RECV,  2'd0, 2'd1, 2'd2, 32'd0, 1'b0));
        d.push_back(make_request(OP_LOCAL, 2'd1, 2'd2, 2'd1, 32'hAAAA_5555, 1'b0));
        d.push_back(make_request(OP_NONE,  2'd0, 2'd0, 2'd0, 32'd0, 1'b0));
        foreach (d[i]) drive_request(d[i]);
    endtask

    // random mix, mostly whole or partial messages in row-major order
    task automatic run_random(input int budget);
        int  sent;
        int  kind;
        int  n;
        int  k;
        bit  ordered;
        t_in r;
        sent = 0;
        while (sent < budget) begin
            kind = $urandom_range(99);
            if (kind < 22) begin
                drive_request(rand_request(OP_LOCAL, 1'($urandom)));
                sent++;
            end else if (kind < 40) begin
                drive_request(rand_request(OP_SEND, 1'($urandom)));
                sent++;
            end else if (kind < 85) begin
                n = $urandom_range(1, CELLS);
                ordered = ($urandom_range(3) != 0);
                for (k = 0; k < n; k++) begin
                    r = rand_request(OP_RECV, k == 0);
                    if (ordered) begin
                        r.in_row = 2'(k / NUM_PROCS);
                        r.in_col = 2'(k % NUM_PROCS);
                    end
                    drive_request(r);
                end
                sent += n;
            end else if (kind < 94) begin
                drive_request(rand_request(OP_RECV, 1'($urandom)));
                sent++;
            end else begin
                drive_request(rand_request(OP_NONE, 1'($urandom)));
            end
        end
    endtask

    // main sequence
    initial begin
        tracker_model = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_own_id(2'd3);
        run_directed();
        settle(CFG_SETTLE);

        // no idling, with one long receiver hold-off while requests keep coming
        write_own_id(2'd0);
        send_idle_pct = 0;  recv_stall_pct = 0;
        run_random(40);
        hold_req = HOLD_CYCLES;
        run_random(35);
        settle(CFG_SETTLE);

        // sender idles
        write_own_id(2'd2);
        send_idle_pct = 47; recv_stall_pct = 0;
        run_random(75);
        settle(CFG_SETTLE);

        // receiver stalls, with a full drain in the middle
        write_own_id(2'd1);
        send_idle_pct = 0;  recv_stall_pct = 47;
        run_random(40);
        settle(0);
        run_random(35);
        settle(CFG_SETTLE);

        // light idling on both sides
        write_own_id(2'd3);
        send_idle_pct = 8;  recv_stall_pct = 8;
        run_random(75);
        settle(END_TAIL);

        $display("covered %0d local events, %0d sends, %0d receive elements, %0d unused ops",
                 tracker_model.n_local, tracker_model.n_send, tracker_model.n_recv,
                 tracker_model.n_ignored);
        $display("%0d matrix entries checked over process ids 0 to 3, %0d errors",
                 tracker_model.entries_checked, tracker_model.errors);
        if (tracker_model.errors == 0 && tracker_model.pending() == 0)
            $display("** matrix_clock_tracker: PASSED **");
        else
            $display("** matrix_clock_tracker: FAILED **");
        $finish;
    end

endmodule
